@@ rtl/drl_pkg.sv @@
// Shared constants, codes and types for the dense rank lookup block.
// No dependencies; imported by drl_search and dense_rank_lookup.
`default_nettype none

package drl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_W     = 31;
  localparam int FUNC_W      = 2;
  localparam int RANK_W      = 9;
  // count holds 0..TABLE_DEPTH, address holds 0..TABLE_DEPTH-1
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // query start request, top level to search engine
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   count;
  } drl_req_t;

  // table read port request, search engine to RAM
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } drl_rd_t;

endpackage

`default_nettype wire

@@ rtl/drl_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module drl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/drl_search.sv @@
// Binary search engine over the sorted score table, with the result register.
// Depends on drl_pkg; reads the table through an external drl_ram.
`default_nettype none

module drl_search
  import drl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire drl_req_t           req,
  output drl_rd_t                 rd,
  input  wire logic [VALUE_W-1:0] rd_data,
  output logic                    busy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [RANK_W-1:0]  rank
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   count_q;
  logic [VALUE_W-1:0] value_q;

  logic [CNT_W-1:0] lo_next;
  logic [CNT_W-1:0] hi_next;
  logic [CNT_W:0]   sum_next;
  logic [CNT_W-1:0] mid_next;
  logic [CNT_W-1:0] mid_start;
  logic             more;
  logic             push;

  // entry at mid is above the query: rank lies beyond it
  always_comb begin
    if (rd_data > value_q) begin
      lo_next = mid + CNT_W'(1);
      hi_next = hi;
    end else begin
      lo_next = lo;
      hi_next = mid;
    end
    sum_next  = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next  = sum_next[CNT_W:1];
    mid_start = req.count >> 1;
    more      = lo_next < hi_next;
  end

  assign busy = (state != ST_IDLE);
  assign push = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    rd.en   = 1'b0;
    rd.addr = mid_next[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        rd.en   = req.start && (req.count != '0);
        rd.addr = mid_start[ADDR_W-1:0];
      end
      ST_SEARCH: begin
        rd.en = more;
      end
      default: begin
        rd.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= (req.count != '0) ? ST_SEARCH : ST_DONE;
          end
        end
        ST_SEARCH: begin
          if (!more) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (push) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.start) begin
      value_q <= req.value;
      count_q <= req.count;
      lo      <= '0;
      hi      <= req.count;
      mid     <= mid_start;
    end else if (state == ST_SEARCH) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
    if (push) begin
      rank <= RANK_W'(lo) + RANK_W'(1);
    end
  end

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> lo < hi && hi <= count_q)
    else $error("search window empty or beyond table fill");

  a_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    rd.en && state == ST_SEARCH |-> CNT_W'(rd.addr) < count_q)
    else $error("table read beyond filled entries");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == ST_IDLE)
    else $error("query started while engine busy");

  a_done_push: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("finished result not moved to output register");

endmodule

`default_nettype wire

@@ rtl/dense_rank_lookup.sv @@
// Timing: load and clear take effect in the cycle after the beat; a query's rank is
// registered after s <= ceil(log2(count+1)) search steps, on leaving ST_DONE
// (an empty table skips the search and goes straight to ST_DONE).
// Input: a query holds off new beats through its search, one table read per search step
// through the single read port, plus any wait for an earlier rank still unaccepted.
// Loads and clears never hold the input. Reset (rst, synchronous): empties the table, drops any
// pending result; the table RAM is not cleared, entries beyond the fill count are never read.
`default_nettype none

module dense_rank_lookup
  import drl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [RANK_W-1:0]  rank
);

  // Fill count of the table and a copy of the last stored score, so a load
  // needs no table read to check descending order.
  logic [CNT_W-1:0]   count;
  logic [VALUE_W-1:0] last_score;

  logic               beat;
  logic               busy;
  logic               load_ok;
  logic               ram_we;
  logic [VALUE_W-1:0] rd_data;
  drl_req_t           req;
  drl_rd_t            rd;

  // One item at a time: a query holds off new beats until its rank is moved into
  // the output register, so a table write never meets a search read of the same entry.
  // A finished rank waits in the output register while new beats are taken.
  assign in_ready = !busy;
  assign beat     = in_valid && in_ready;

  // Append only below the last score, and only while there is room.
  assign load_ok = (count != CNT_W'(TABLE_DEPTH)) &&
                   ((count == '0) || (value < last_score));

  always_comb begin
    ram_we    = 1'b0;
    req.start = 1'b0;
    req.value = value;
    req.count = count;
    if (beat) begin
      unique case (func)
        FUNC_LOAD:  ram_we    = load_ok;
        FUNC_QUERY: req.start = 1'b1;
        default:    ram_we    = 1'b0;   // clear handled below; unused code ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (beat && func == FUNC_CLEAR) begin
      count <= '0;
    end else if (ram_we) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_score <= value;
    end
  end

  drl_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (value),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  drl_search u_search (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rd        (rd),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rank      (rank)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_load_grows: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> count == $past(count) + CNT_W'(1))
    else $error("accepted load did not advance fill count");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !busy)
    else $error("table written during a search");

endmodule

`default_nettype wire
